// File: design/chs_pkg.sv
// Shared constants, a type and a lookup function for the disk CHS geometry unit.
`default_nettype none

package chs_pkg;

   // Datapath widths.
   localparam int DIVIDEND_W     = 64;
   localparam int DIVISOR_W      = 17;
   localparam int QUOT_W         = 28;
   localparam int BITS_PER_STAGE = 4;
   localparam int CTH_W          = 24;
   localparam int RECIP_W        = 32;
   localparam int RECIP_SHIFT    = 36;
   localparam int HEAD_RECIP_W   = 19;
   localparam int HEAD_RECIP_SHIFT = 20;
   localparam int SMALL_CTH_W    = 14;
   localparam int SMALL_CYL_W    = 10;
   localparam int CYL_W          = 16;
   localparam int HEAD_W         = 5;
   localparam int SPT_W          = 8;
   localparam int HEAD_SHIFT     = 10;

   // Configuration port.
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_INDEX_SECTOR_BYTES = 1'b0;
   localparam logic [DIVISOR_W-1:0] SECTOR_BYTES_RESET = 17'd512;

   // Sector count clamp (65535 * 16 * 255) and large-disk threshold (65535 * 16 * 63).
   localparam logic [QUOT_W-1:0] TOTAL_LIMIT = 28'd267382800;
   localparam logic [QUOT_W-1:0] TOTAL_BIG   = 28'd66059280;

   // Reciprocals ceil(2^36 / d); exact for every dividend below 2^28.
   localparam logic [RECIP_W-1:0] RECIP_17  = 32'd4042322161;
   localparam logic [RECIP_W-1:0] RECIP_31  = 32'd2216757315;
   localparam logic [RECIP_W-1:0] RECIP_63  = 32'd1090785346;
   localparam logic [RECIP_W-1:0] RECIP_255 = 32'd269488145;

   // Geometry codes.
   localparam logic [SPT_W-1:0]  SPT_SMALL  = 8'd17;
   localparam logic [SPT_W-1:0]  SPT_MID    = 8'd31;
   localparam logic [SPT_W-1:0]  SPT_LARGE  = 8'd63;
   localparam logic [SPT_W-1:0]  SPT_MAX    = 8'd255;
   localparam logic [HEAD_W-1:0] HEADS_MIN  = 5'd4;
   localparam logic [HEAD_W-1:0] HEADS_MAX  = 5'd16;
   localparam logic [CTH_W:0]    HEAD_ROUND = 25'd1023;
   localparam logic [CTH_W-1:0]  CTH_FULL   = 24'd16384;

   // Sector count leaving the divider, with its valid bit.
   typedef struct packed {
      logic              valid;
      logic [QUOT_W-1:0] total;
   } chs_total_type;

   // Reciprocal ceil(2^20 / heads) for the head counts of the small-disk case.
   function automatic logic [HEAD_RECIP_W-1:0] head_recip(input logic [HEAD_W-1:0] heads);
      logic [HEAD_RECIP_W-1:0] r;
      unique case (heads)
         5'd4:    r = 19'd262144;
         5'd5:    r = 19'd209716;
         5'd6:    r = 19'd174763;
         5'd7:    r = 19'd149797;
         5'd8:    r = 19'd131072;
         5'd9:    r = 19'd116509;
         5'd10:   r = 19'd104858;
         5'd11:   r = 19'd95326;
         5'd12:   r = 19'd87382;
         5'd13:   r = 19'd80660;
         5'd14:   r = 19'd74899;
         5'd15:   r = 19'd69906;
         5'd16:   r = 19'd65536;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// File: design/disk_chs_geometry_unit.sv
// Top level of the disk CHS geometry unit: command port, register port, pipeline.
`default_nettype none

// The unit takes a disk size in bytes on each start and returns its VHD
// cylinder/head/sector geometry as a one-cycle rsp_valid strobe. busy is
// always low: a new transaction may start in every cycle, and the results come
// back in order at the same rate, so the receiver must take one result per
// cycle whenever the strobe is high. The pipeline is the divider (one entry
// stage, seven stages of four quotient bits each, one clamp stage) followed by
// three geometry stages (reciprocal multiply, track selection, cylinder
// divide). sector_bytes lives at byte address 0 of the register port and is
// sampled with each transaction as it enters; change it only while no
// transaction is in flight.
module disk_chs_geometry_unit
   import chs_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Command channel.
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [DIVIDEND_W-1:0] req_disk_bytes,
   // Result channel.
   output logic                       rsp_valid,
   output logic [CYL_W-1:0]           rsp_cylinder_count,
   output logic [HEAD_W-1:0]          rsp_head_count,
   output logic [SPT_W-1:0]           rsp_sectors_per_track,
   // Register port.
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0]      prdata,
   output logic                       pready
);

   logic [DIVISOR_W-1:0] sector_bytes_reg_ff;
   logic [DIVISOR_W-1:0] sector_bytes_in;
   logic                 csr_write;
   logic                 csr_index;
   chs_total_type        total;

   // Register port: zero wait states.
   assign pready    = 1'b1;
   assign csr_index = paddr[2];
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      sector_bytes_in = sector_bytes_reg_ff;
      if (csr_write && (csr_index == CSR_INDEX_SECTOR_BYTES)) begin
         sector_bytes_in = pwdata[DIVISOR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sector_bytes_reg_ff <= SECTOR_BYTES_RESET;
      end else begin
         sector_bytes_reg_ff <= sector_bytes_in;
      end
   end

   // Read back.
   always_comb begin
      unique case (csr_index)
         CSR_INDEX_SECTOR_BYTES:
            prdata = {{(CSR_DATA_W-DIVISOR_W){1'b0}}, sector_bytes_reg_ff};
         default:
            prdata = '0;
      endcase
   end

   // The pipeline never stalls, so a transaction is taken on every start.
   assign busy = 1'b0;

   chs_div u_div (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (start && !busy),
      .in_dividend (req_disk_bytes),
      .in_divisor  (sector_bytes_reg_ff),
      .out_total   (total)
   );

   chs_geom u_geom (
      .clock                 (clock),
      .reset                 (reset),
      .in_total              (total),
      .out_valid             (rsp_valid),
      .out_cylinder_count    (rsp_cylinder_count),
      .out_head_count        (rsp_head_count),
      .out_sectors_per_track (rsp_sectors_per_track)
   );

endmodule

`default_nettype wire

// File: design/chs_div.sv
// Pipelined divider that turns a byte count into a clamped 28-bit sector count.
`default_nettype none

module chs_div
   import chs_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   input  wire logic [DIVIDEND_W-1:0] in_dividend,
   input  wire logic [DIVISOR_W-1:0]  in_divisor,
   output chs_total_type              out_total
);

   localparam int STAGES = QUOT_W / BITS_PER_STAGE;
   localparam int HI_W   = DIVIDEND_W - QUOT_W;

   logic                 valid_ff   [STAGES+1];
   logic                 ovf_ff     [STAGES+1];
   logic [DIVISOR_W-1:0] rem_ff     [STAGES+1];
   logic [QUOT_W-1:0]    lo_ff      [STAGES+1];
   logic [DIVISOR_W-1:0] divisor_ff [STAGES+1];
   logic [DIVISOR_W-1:0] rem_in     [STAGES];
   logic [QUOT_W-1:0]    lo_in      [STAGES];
   logic                 ovf_in;
   chs_total_type        total_ff;
   chs_total_type        total_in;

   // The quotient fits 28 bits only when the upper dividend bits are below the divisor.
   // A zero divisor always fails this test, which saturates the count.
   assign ovf_in = in_dividend[DIVIDEND_W-1:QUOT_W] >= {{(HI_W-DIVISOR_W){1'b0}}, in_divisor};

   // Entry stage: the upper bits become the starting remainder.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
      end
      ovf_ff[0]     <= ovf_in;
      rem_ff[0]     <= in_dividend[QUOT_W+DIVISOR_W-1:QUOT_W];
      lo_ff[0]      <= in_dividend[QUOT_W-1:0];
      divisor_ff[0] <= in_divisor;
   end

   // Restoring division, four quotient bits per stage shifted into the low word.
   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      always_comb begin : step
         logic [DIVISOR_W:0]   trial;
         logic [DIVISOR_W-1:0] rem_v;
         logic [QUOT_W-1:0]    lo_v;
         rem_v = rem_ff[s];
         lo_v  = lo_ff[s];
         for (int j = 0; j < BITS_PER_STAGE; j++) begin
            trial = {rem_v, lo_v[QUOT_W-1]};
            lo_v  = {lo_v[QUOT_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor_ff[s]}) begin
               trial   = trial - {1'b0, divisor_ff[s]};
               lo_v[0] = 1'b1;
            end
            rem_v = trial[DIVISOR_W-1:0];
         end
         rem_in[s] = rem_v;
         lo_in[s]  = lo_v;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s+1] <= 1'b0;
         end else begin
            valid_ff[s+1] <= valid_ff[s];
         end
         ovf_ff[s+1]     <= ovf_ff[s];
         rem_ff[s+1]     <= rem_in[s];
         lo_ff[s+1]      <= lo_in[s];
         divisor_ff[s+1] <= divisor_ff[s];
      end
   end

   // Clamp the quotient to the largest geometry.
   always_comb begin
      total_in.valid = valid_ff[STAGES];
      if (ovf_ff[STAGES] || (lo_ff[STAGES] > TOTAL_LIMIT)) begin
         total_in.total = TOTAL_LIMIT;
      end else begin
         total_in.total = lo_ff[STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff.valid <= 1'b0;
      end else begin
         total_ff.valid <= total_in.valid;
      end
      total_ff.total <= total_in.total;
   end

   assign out_total = total_ff;

endmodule

`default_nettype wire

// File: design/chs_geom.sv
// Geometry stages: sector count to cylinders, heads and sectors per track.
`default_nettype none

module chs_geom
   import chs_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire chs_total_type     in_total,
   output logic                   out_valid,
   output logic [CYL_W-1:0]       out_cylinder_count,
   output logic [HEAD_W-1:0]      out_head_count,
   output logic [SPT_W-1:0]       out_sectors_per_track
);

   localparam int PROD_W      = QUOT_W + RECIP_W;
   localparam int HEAD_PROD_W = SMALL_CTH_W + HEAD_RECIP_W;
   localparam int HRAW_W      = CTH_W + 1 - HEAD_SHIFT;

   // Stage 1: the four constant divisions by reciprocal multiplication.
   logic [PROD_W-1:0] prod17, prod31, prod63, prod255;
   logic              v1_ff;
   logic              big_ff;
   logic [CTH_W-1:0]  q17_ff, q31_ff, q63_ff, q255_ff;

   assign prod17  = in_total.total * RECIP_17;
   assign prod31  = in_total.total * RECIP_31;
   assign prod63  = in_total.total * RECIP_63;
   assign prod255 = in_total.total * RECIP_255;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= in_total.valid;
      end
      big_ff  <= in_total.total >= TOTAL_BIG;
      q17_ff  <= prod17[RECIP_SHIFT +: CTH_W];
      q31_ff  <= prod31[RECIP_SHIFT +: CTH_W];
      q63_ff  <= prod63[RECIP_SHIFT +: CTH_W];
      q255_ff <= prod255[RECIP_SHIFT +: CTH_W];
   end

   // Stage 2: pick the sectors per track and head count.
   logic [CTH_W:0]      round_sum;
   logic [HRAW_W-1:0]   h_raw;
   logic [HRAW_W-1:0]   h17;
   logic                fail17;
   logic                fail31;
   logic [SPT_W-1:0]    spt_in;
   logic [HEAD_W-1:0]   heads_in;
   logic [CTH_W-1:0]    cth_in;
   logic                v2_ff;
   logic [SPT_W-1:0]    spt_ff;
   logic [HEAD_W-1:0]   heads_ff;
   logic [CTH_W-1:0]    cth_ff;

   always_comb begin
      round_sum = {1'b0, q17_ff} + HEAD_ROUND;
      h_raw     = round_sum[CTH_W:HEAD_SHIFT];
      h17       = (h_raw < HRAW_W'(HEADS_MIN)) ? HRAW_W'(HEADS_MIN) : h_raw;
      fail17    = ({h17, {HEAD_SHIFT{1'b0}}} <= {1'b0, q17_ff})
                  || (h17 > HRAW_W'(HEADS_MAX));
      fail31    = q31_ff >= CTH_FULL;

      if (big_ff) begin
         spt_in   = SPT_MAX;
         heads_in = HEADS_MAX;
         cth_in   = q255_ff;
      end else if (!fail17) begin
         spt_in   = SPT_SMALL;
         heads_in = h17[HEAD_W-1:0];
         cth_in   = q17_ff;
      end else if (!fail31) begin
         spt_in   = SPT_MID;
         heads_in = HEADS_MAX;
         cth_in   = q31_ff;
      end else begin
         spt_in   = SPT_LARGE;
         heads_in = HEADS_MAX;
         cth_in   = q63_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      spt_ff   <= spt_in;
      heads_ff <= heads_in;
      cth_ff   <= cth_in;
   end

   // Stage 3: cylinders. Sixteen heads is a shift; fewer heads only occur with
   // fewer than 16384 track groups, where a reciprocal table gives the exact quotient.
   logic [HEAD_PROD_W-1:0] head_prod;
   logic [CYL_W-1:0]       cyl_in;
   logic                   v3_ff;
   logic [CYL_W-1:0]       cyl_ff;
   logic [HEAD_W-1:0]      heads3_ff;
   logic [SPT_W-1:0]       spt3_ff;

   assign head_prod = cth_ff[SMALL_CTH_W-1:0] * head_recip(heads_ff);

   always_comb begin
      if (heads_ff == HEADS_MAX) begin
         cyl_in = cth_ff[CYL_W+3:4];
      end else begin
         cyl_in = {{(CYL_W-SMALL_CYL_W){1'b0}},
                   head_prod[HEAD_RECIP_SHIFT +: SMALL_CYL_W]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      cyl_ff    <= cyl_in;
      heads3_ff <= heads_ff;
      spt3_ff   <= spt_ff;
   end

   assign out_valid             = v3_ff;
   assign out_cylinder_count    = cyl_ff;
   assign out_head_count        = heads3_ff;
   assign out_sectors_per_track = spt3_ff;

endmodule

`default_nettype wire
